FILE: hw/rtl/dsa_pkg.sv
`timescale 1ns / 1ps

package dsa_pkg;

  localparam logic [1:0] CMD_EVENT    = 2'd0;
  localparam logic [1:0] CMD_INTERVAL = 2'd1;
  localparam logic [1:0] CMD_FINISH   = 2'd2;
  localparam logic [1:0] CMD_UNUSED   = 2'd3;

  localparam logic [15:0] TRACE_LENGTH_RESET = 16'd10000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WDIV,
    ST_WMUL,
    ST_WACC,
    ST_BDIV,
    ST_FDIV,
    ST_VSTART,
    ST_VDIV,
    ST_SQRT,
    ST_QDIV,
    ST_OUT
  } dsa_state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } dsa_div_req_t;

endpackage

FILE: hw/rtl/dsa_div.sv
`timescale 1ns / 1ps

module dsa_div
  import dsa_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  dsa_div_req_t req,
  output logic         done,
  output logic [63:0]  quotient
);

  logic [63:0] quo_r;
  logic [31:0] rem_r;
  logic [31:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        ge;

  assign rem_sh  = {rem_r, quo_r[63]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign ge      = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        quo_r  <= req.dividend;
        dvs_r  <= req.divisor;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? rem_sub[31:0] : rem_sh[31:0];
        quo_r <= {quo_r[62:0], ge};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: hw/rtl/dsa_sqrt.sv
`timescale 1ns / 1ps

module dsa_sqrt
  import dsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] rad_r;
  logic [33:0] rem_r;
  logic [31:0] root_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic [35:0] rem_sub;
  logic        ge;

  assign rem_sh  = {rem_r, rad_r[63:62]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign rem_sub = rem_sh - trial;
  assign ge      = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rad_r  <= {rad_r[61:0], 2'b00};
        rem_r  <= ge ? rem_sub[33:0] : rem_sh[33:0];
        root_r <= {root_r[30:0], ge};
        cnt_r  <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

FILE: hw/rtl/duration_stats_accumulator_top.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake               Word
// in       input      in_valid / in_ready     command, duration, clipped_duration
// out      output     out_valid / out_ready   eight report fields
// cfg      input      cfg_wr_en               trace_length, written at once
//
// A sample runs a 64-step serial divide and then a 32-step multiply.
// A finish runs up to six 64-step divides and up to two 32-step roots.
// The 64-step bit-serial divider dominates both sequences.
// Reset is synchronous and active low; it restores the trace length and clears all totals.
// A finished report waits in the output register; new words are taken meanwhile.

module duration_stats_accumulator_top
  import dsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_duration,
  input  logic [15:0] in_clipped_duration,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_busy_ratio,
  output logic [31:0] out_event_mean,
  output logic [31:0] out_interval_mean,
  output logic [31:0] out_event_variation,
  output logic [31:0] out_interval_variation,
  output logic [16:0] out_event_frequency,
  output logic [15:0] out_longest_event,
  output logic [15:0] out_shortest_event,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  dsa_state_t   state_r, state_nxt;
  dsa_div_req_t div_req;
  logic         div_done;
  logic [63:0]  div_quo;
  logic         sqrt_start;
  logic [63:0]  sqrt_rad;
  logic         sqrt_done;
  logic [31:0]  sqrt_root;

  logic [15:0] trace_len_r;
  logic [15:0] ev_cnt_r, iv_cnt_r;
  logic [31:0] busy_r;
  logic [31:0] ev_mean_r, iv_mean_r;
  logic [63:0] ev_dev_r, iv_dev_r;
  logic [15:0] max_r, min_r;

  logic        sel_r;
  logic        neg_r;
  logic [31:0] x_r;
  logic [4:0]  cnt_r;
  logic [63:0] mcand_r;
  logic [31:0] mplier_r;
  logic [63:0] prod_r;

  logic [31:0] res_busy_r, res_evar_r, res_ivar_r;
  logic [16:0] res_freq_r;

  logic        out_valid_r;
  logic [31:0] out_busy_r, out_emean_r, out_imean_r, out_evar_r, out_ivar_r;
  logic [16:0] out_freq_r;
  logic [15:0] out_max_r, out_min_r;

  logic        accept;
  logic        in_sel;
  logic [31:0] acc_mean;
  logic [15:0] acc_cnt, acc_cnt_inc;
  logic [31:0] x_in;
  logic        x_ge;
  logic [31:0] diff_in;
  logic [15:0] tl_eff;
  logic [31:0] sel_mean;
  logic [15:0] sel_cnt;
  logic [63:0] sel_dev;
  logic        var_zero;
  logic [31:0] nw;
  logic [31:0] d2;
  logic [64:0] dev_sum;
  logic [31:0] add_clip;
  logic [32:0] busy_sum;
  logic [47:0] v_clamp;
  logic [31:0] q_sat32;
  logic        out_free;

  assign accept      = in_valid && in_ready;
  assign in_sel      = (in_command == CMD_INTERVAL);
  assign acc_mean    = in_sel ? iv_mean_r : ev_mean_r;
  assign acc_cnt     = in_sel ? iv_cnt_r : ev_cnt_r;
  assign acc_cnt_inc = (acc_cnt == 16'hFFFF) ? acc_cnt : acc_cnt + 16'd1;
  assign x_in        = {in_duration, 16'h0000};
  assign x_ge        = x_in >= acc_mean;
  assign diff_in     = x_ge ? x_in - acc_mean : acc_mean - x_in;
  assign tl_eff      = (trace_len_r == 16'd0) ? 16'd1 : trace_len_r;
  assign sel_mean    = sel_r ? iv_mean_r : ev_mean_r;
  assign sel_cnt     = sel_r ? iv_cnt_r : ev_cnt_r;
  assign sel_dev     = sel_r ? iv_dev_r : ev_dev_r;
  assign var_zero    = (sel_cnt == 16'd0) || (sel_mean == 32'd0);
  assign nw          = neg_r ? sel_mean - div_quo[31:0] : sel_mean + div_quo[31:0];
  assign d2          = (x_r >= nw) ? x_r - nw : nw - x_r;
  assign dev_sum     = {1'b0, sel_dev} + {17'd0, prod_r[63:16]};
  assign add_clip    = {16'd0, in_clipped_duration} + 32'd1;
  assign busy_sum    = {1'b0, busy_r} + {1'b0, add_clip};
  assign v_clamp     = (div_quo[63:48] != 16'd0) ? {48{1'b1}} : div_quo[47:0];
  assign q_sat32     = (div_quo[63:32] != 32'd0) ? 32'hFFFF_FFFF : div_quo[31:0];
  assign out_free    = !out_valid_r || out_ready;

  dsa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  dsa_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sqrt_rad),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_command == CMD_EVENT || in_command == CMD_INTERVAL) begin
            state_nxt = ST_WDIV;
          end else if (in_command == CMD_FINISH) begin
            state_nxt = ST_BDIV;
          end
        end
      end
      ST_WDIV:   if (div_done) state_nxt = ST_WMUL;
      ST_WMUL:   if (cnt_r == 5'd31) state_nxt = ST_WACC;
      ST_WACC:   state_nxt = ST_IDLE;
      ST_BDIV:   if (div_done) state_nxt = ST_FDIV;
      ST_FDIV:   if (div_done) state_nxt = ST_VSTART;
      ST_VSTART: begin
        if (var_zero) begin
          state_nxt = sel_r ? ST_OUT : ST_VSTART;
        end else begin
          state_nxt = ST_VDIV;
        end
      end
      ST_VDIV:   if (div_done) state_nxt = ST_SQRT;
      ST_SQRT:   if (sqrt_done) state_nxt = ST_QDIV;
      ST_QDIV:   if (div_done) state_nxt = sel_r ? ST_OUT : ST_VSTART;
      ST_OUT:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    div_req    = '0;
    sqrt_start = 1'b0;
    sqrt_rad   = {v_clamp, 16'h0000};
    in_ready   = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_command == CMD_EVENT || in_command == CMD_INTERVAL)) begin
          div_req.start    = 1'b1;
          div_req.dividend = {32'd0, diff_in};
          div_req.divisor  = {16'd0, acc_cnt_inc};
        end else if (accept && in_command == CMD_FINISH) begin
          div_req.start    = 1'b1;
          div_req.dividend = {16'd0, busy_r, 16'h0000};
          div_req.divisor  = {16'd0, tl_eff};
        end
      end
      ST_BDIV: begin
        if (div_done) begin
          div_req.start    = 1'b1;
          div_req.dividend = {32'd0, ev_cnt_r, 16'h0000};
          div_req.divisor  = {16'd0, tl_eff};
        end
      end
      ST_VSTART: begin
        if (!var_zero) begin
          div_req.start    = 1'b1;
          div_req.dividend = sel_dev;
          div_req.divisor  = {16'd0, sel_cnt};
        end
      end
      ST_VDIV: begin
        sqrt_start = div_done;
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          div_req.start    = 1'b1;
          div_req.dividend = {16'd0, sqrt_root, 16'h0000};
          div_req.divisor  = sel_mean;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          sel_r    <= in_sel;
          neg_r    <= !x_ge;
          x_r      <= x_in;
          mplier_r <= diff_in;
        end
      end
      ST_WDIV: begin
        if (div_done) begin
          mcand_r <= {32'd0, d2};
          prod_r  <= '0;
          cnt_r   <= '0;
        end
      end
      ST_WMUL: begin
        if (mplier_r[0]) begin
          prod_r <= prod_r + mcand_r;
        end
        mcand_r  <= {mcand_r[62:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[31:1]};
        cnt_r    <= cnt_r + 5'd1;
      end
      ST_BDIV: begin
        if (div_done) res_busy_r <= q_sat32;
      end
      ST_FDIV: begin
        if (div_done) begin
          res_freq_r <= (div_quo[63:17] != 47'd0) ? 17'h1FFFF : div_quo[16:0];
          sel_r      <= 1'b0;
        end
      end
      ST_VSTART: begin
        if (var_zero) begin
          if (sel_r) res_ivar_r <= '0;
          else       res_evar_r <= '0;
          sel_r <= 1'b1;
        end
      end
      ST_QDIV: begin
        if (div_done) begin
          if (sel_r) res_ivar_r <= q_sat32;
          else       res_evar_r <= q_sat32;
          sel_r <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_busy_r  <= res_busy_r;
      out_emean_r <= ev_mean_r;
      out_imean_r <= iv_mean_r;
      out_evar_r  <= res_evar_r;
      out_ivar_r  <= res_ivar_r;
      out_freq_r  <= res_freq_r;
      out_max_r   <= max_r;
      out_min_r   <= min_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trace_len_r <= TRACE_LENGTH_RESET;
      ev_cnt_r    <= '0;
      iv_cnt_r    <= '0;
      busy_r      <= '0;
      ev_mean_r   <= '0;
      iv_mean_r   <= '0;
      ev_dev_r    <= '0;
      iv_dev_r    <= '0;
      max_r       <= '0;
      min_r       <= TRACE_LENGTH_RESET;
    end else begin
      if (state_r == ST_IDLE && accept) begin
        if (in_command == CMD_EVENT) begin
          ev_cnt_r <= acc_cnt_inc;
          busy_r   <= busy_sum[32] ? 32'hFFFF_FFFF : busy_sum[31:0];
          if (in_duration > max_r) max_r <= in_duration;
          if (in_duration < min_r) min_r <= in_duration;
        end else if (in_command == CMD_INTERVAL) begin
          iv_cnt_r <= acc_cnt_inc;
        end
      end
      if (state_r == ST_WDIV && div_done) begin
        if (sel_r) iv_mean_r <= nw;
        else       ev_mean_r <= nw;
      end
      if (state_r == ST_WACC) begin
        if (sel_r) iv_dev_r <= dev_sum[64] ? {64{1'b1}} : dev_sum[63:0];
        else       ev_dev_r <= dev_sum[64] ? {64{1'b1}} : dev_sum[63:0];
      end
      if (state_r == ST_OUT && out_free) begin
        ev_cnt_r  <= '0;
        iv_cnt_r  <= '0;
        busy_r    <= '0;
        ev_mean_r <= '0;
        iv_mean_r <= '0;
        ev_dev_r  <= '0;
        iv_dev_r  <= '0;
        max_r     <= '0;
        min_r     <= trace_len_r;
      end
      if (cfg_wr_en) begin
        trace_len_r <= cfg_wr_data;
        if (ev_cnt_r == 16'd0) min_r <= cfg_wr_data;
      end
    end
  end

  assign out_valid              = out_valid_r;
  assign out_busy_ratio         = out_busy_r;
  assign out_event_mean         = out_emean_r;
  assign out_interval_mean      = out_imean_r;
  assign out_event_variation    = out_evar_r;
  assign out_interval_variation = out_ivar_r;
  assign out_event_frequency    = out_freq_r;
  assign out_longest_event      = out_max_r;
  assign out_shortest_event     = out_min_r;

endmodule

FILE: hw/rtl/dsa_checker.sv
`timescale 1ns / 1ps

module dsa_checker
  import dsa_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_command,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_busy_ratio,
  input logic [16:0] out_event_frequency,
  input logic [15:0] out_longest_event,
  input logic [15:0] out_shortest_event
);

  // A stalled report word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_busy_ratio))
    else $error("report changed while stalled");

  // A real command occupies the block for the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command != CMD_UNUSED |=> !in_ready)
    else $error("input taken again right after a command");

  // A report is loaded only at the end of the finish sequence.
  a_report_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("report appeared while idle");

  // Once events were seen, the shortest never exceeds the longest.
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_frequency != 17'd0 |-> out_shortest_event <= out_longest_event)
    else $error("shortest event above longest");

endmodule

bind duration_stats_accumulator_top dsa_checker u_dsa_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .in_command          (in_command),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_busy_ratio      (out_busy_ratio),
  .out_event_frequency (out_event_frequency),
  .out_longest_event   (out_longest_event),
  .out_shortest_event  (out_shortest_event)
);
